@@ hdl/fxq_alu_pkg.sv @@
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; imported by the divider cell and the top level.
package fxq_alu_pkg;

   localparam int PORT_WIDTH     = 32;
   localparam int FUNC_WIDTH     = 4;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int WORD_WIDTH_DEF = 32;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_ADD   = 4'd0,
      FUNC_SUB   = 4'd1,
      FUNC_MUL   = 4'd2,
      FUNC_DIV   = 4'd3,
      FUNC_LT    = 4'd4,
      FUNC_GT    = 4'd5,
      FUNC_LE    = 4'd6,
      FUNC_GE    = 4'd7,
      FUNC_EQ    = 4'd8,
      FUNC_NE    = 4'd9,
      FUNC_MIN   = 4'd10,
      FUNC_MAX   = 4'd11,
      FUNC_INC   = 4'd12,
      FUNC_DEC   = 4'd13,
      FUNC_TOINT = 4'd14
   } func_type;

   // Control that rides along with each item through the divider chain.
   typedef struct packed {
      logic valid;
      logic is_div;
      logic neg;
      logic cmp;
      logic dz;
   } ctl_type;

endpackage

@@ hdl/fxq_div_cell.sv @@
// One cell of the divider chain: a restoring-divide step for one quotient bit.
// Depends on fxq_alu_pkg.
module fxq_div_cell #(
   parameter int WORD_WIDTH = 32,
   parameter int QUOT_WIDTH = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fxq_alu_pkg::ctl_type      ctl_in,
   input  logic [WORD_WIDTH-1:0]     side_in,
   input  logic [QUOT_WIDTH-1:0]     work_in,
   input  logic [WORD_WIDTH-1:0]     rem_in,
   input  logic [WORD_WIDTH-1:0]     den_in,
   output fxq_alu_pkg::ctl_type      ctl_out,
   output logic [WORD_WIDTH-1:0]     side_out,
   output logic [QUOT_WIDTH-1:0]     work_out,
   output logic [WORD_WIDTH-1:0]     rem_out,
   output logic [WORD_WIDTH-1:0]     den_out
);
   import fxq_alu_pkg::*;

   ctl_type               ctl_ff;
   logic [WORD_WIDTH-1:0] side_ff, rem_ff, rem_in_nx, den_ff;
   logic [QUOT_WIDTH-1:0] work_ff, work_in_nx;
   logic [WORD_WIDTH:0]   shifted, trial;
   logic                  ge;

   // work holds the remaining dividend bits on top and the quotient bits below
   always_comb begin
      shifted    = {rem_in, work_in[QUOT_WIDTH-1]};
      trial      = shifted - {1'b0, den_in};
      ge         = shifted >= {1'b0, den_in};
      rem_in_nx  = ge ? trial[WORD_WIDTH-1:0] : shifted[WORD_WIDTH-1:0];
      work_in_nx = {work_in[QUOT_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      work_ff <= work_in_nx;
      rem_ff  <= rem_in_nx;
      den_ff  <= den_in;
   end

   assign ctl_out  = ctl_ff;
   assign side_out = side_ff;
   assign work_out = work_ff;
   assign rem_out  = rem_ff;
   assign den_out  = den_ff;

endmodule

@@ hdl/fixed_point_q24_8_alu_unit.sv @@
// Top level of the Q24.8 fixed-point ALU: operand stage, divider chain, output.
// Depends on fxq_alu_pkg and fxq_div_cell.
//
// Usage:
//   A request is transferred at a rising edge with start high and busy low.
//   busy is always low, so one request may be issued every cycle.
//   req_func selects the operation; req_a_operand and req_b_operand are raw
//   Q24.8 words (only the low WORD_WIDTH bits are used, sign-extended).
//   Every request yields exactly one response, flagged by rsp_valid for one
//   cycle, in request order.
//   The divider sets the delay, the same for every operation: all operations
//   flow through a chain of WORD_WIDTH + FRAC_BITS cells, one quotient bit
//   per cell, plus the operand register in front and the output register
//   behind it.
//   Throughput: one operation per cycle.
//   Reset clears all valid flags in flight; no responses follow it until new
//   requests arrive. The receiver cannot stall: each response is presented
//   for exactly one cycle.
module fixed_point_q24_8_alu_unit #(
   parameter int FRAC_BITS  = fxq_alu_pkg::FRAC_BITS_DEF,
   parameter int WORD_WIDTH = fxq_alu_pkg::WORD_WIDTH_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic [fxq_alu_pkg::FUNC_WIDTH-1:0]          req_func,
   input  logic signed [fxq_alu_pkg::PORT_WIDTH-1:0]   req_a_operand,
   input  logic signed [fxq_alu_pkg::PORT_WIDTH-1:0]   req_b_operand,
   output logic                                        rsp_valid,
   output logic signed [fxq_alu_pkg::PORT_WIDTH-1:0]   rsp_result_raw,
   output logic                                        rsp_compare_true,
   output logic                                        rsp_div_by_zero
);
   import fxq_alu_pkg::*;

   localparam int QW = WORD_WIDTH + FRAC_BITS;

   logic signed [WORD_WIDTH-1:0]   a_w, b_w, toint_sum;
   logic [WORD_WIDTH-1:0]          abs_a, abs_b, simple_r;
   logic                           cmp_c, dz_c, div_c, mul_c;
   func_type                       func_c;

   ctl_type                        ctl_ff, ctl_in;
   logic                           mul_ff, mul_in;
   logic [WORD_WIDTH-1:0]          side_ff, side_in, den_ff, den_in;
   logic signed [2*WORD_WIDTH-1:0] prod_ff, prod_in, prod_sh;
   logic [QW-1:0]                  num_ff, num_in;
   logic [WORD_WIDTH-1:0]          side0;

   ctl_type               ctl_ch  [QW+1];
   logic [WORD_WIDTH-1:0] side_ch [QW+1];
   logic [QW-1:0]         work_ch [QW+1];
   logic [WORD_WIDTH-1:0] rem_ch  [QW+1];
   logic [WORD_WIDTH-1:0] den_ch  [QW+1];

   logic [QW-1:0]                 quot;
   logic [WORD_WIDTH-1:0]         final_w;
   logic                          out_valid_ff, out_valid_in;
   logic signed [PORT_WIDTH-1:0]  out_res_ff, out_res_in;
   logic                          out_cmp_ff, out_cmp_in, out_dz_ff, out_dz_in;

   assign busy = 1'b0;

   // Operand stage
   always_comb begin
      a_w       = req_a_operand[WORD_WIDTH-1:0];
      b_w       = req_b_operand[WORD_WIDTH-1:0];
      func_c    = func_type'(req_func);
      abs_a     = a_w[WORD_WIDTH-1] ? -a_w : a_w;
      abs_b     = b_w[WORD_WIDTH-1] ? -b_w : b_w;
      // truncate toward zero: bias negatives before the arithmetic shift
      toint_sum = a_w + (a_w[WORD_WIDTH-1] ? WORD_WIDTH'((1 << FRAC_BITS) - 1)
                                           : WORD_WIDTH'(0));
      simple_r  = '0;
      cmp_c     = 1'b0;
      dz_c      = 1'b0;
      div_c     = 1'b0;
      mul_c     = 1'b0;
      unique case (func_c)
         FUNC_ADD:   simple_r = a_w + b_w;
         FUNC_SUB:   simple_r = a_w - b_w;
         FUNC_MUL:   mul_c = 1'b1;
         FUNC_DIV: begin
            if (b_w == '0) dz_c = 1'b1;
            else           div_c = 1'b1;
         end
         FUNC_LT:    cmp_c = a_w <  b_w;
         FUNC_GT:    cmp_c = a_w >  b_w;
         FUNC_LE:    cmp_c = a_w <= b_w;
         FUNC_GE:    cmp_c = a_w >= b_w;
         FUNC_EQ:    cmp_c = a_w == b_w;
         FUNC_NE:    cmp_c = a_w != b_w;
         FUNC_MIN:   simple_r = (a_w > b_w) ? b_w : a_w;
         FUNC_MAX:   simple_r = (a_w > b_w) ? a_w : b_w;
         FUNC_INC:   simple_r = a_w + WORD_WIDTH'(1);
         FUNC_DEC:   simple_r = a_w - WORD_WIDTH'(1);
         FUNC_TOINT: simple_r = toint_sum >>> FRAC_BITS;
         default:    simple_r = '0;
      endcase
      ctl_in.valid  = start;
      ctl_in.is_div = div_c;
      ctl_in.neg    = a_w[WORD_WIDTH-1] ^ b_w[WORD_WIDTH-1];
      ctl_in.cmp    = cmp_c;
      ctl_in.dz     = dz_c;
      mul_in        = mul_c;
      side_in       = simple_r;
      prod_in       = a_w * b_w;
      num_in        = {abs_a, {FRAC_BITS{1'b0}}};
      den_in        = abs_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff  <= mul_in;
      side_ff <= side_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign side0   = mul_ff ? prod_sh[WORD_WIDTH-1:0] : side_ff;

   assign ctl_ch[0]  = ctl_ff;
   assign side_ch[0] = side0;
   assign work_ch[0] = num_ff;
   assign rem_ch[0]  = '0;
   assign den_ch[0]  = den_ff;

   for (genvar i = 0; i < QW; i++) begin : g_cell
      fxq_div_cell #(
         .WORD_WIDTH (WORD_WIDTH),
         .QUOT_WIDTH (QW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (ctl_ch[i]),
         .side_in  (side_ch[i]),
         .work_in  (work_ch[i]),
         .rem_in   (rem_ch[i]),
         .den_in   (den_ch[i]),
         .ctl_out  (ctl_ch[i+1]),
         .side_out (side_ch[i+1]),
         .work_out (work_ch[i+1]),
         .rem_out  (rem_ch[i+1]),
         .den_out  (den_ch[i+1])
      );
   end

   // Output stage: sign the quotient and pick the result
   always_comb begin
      quot         = ctl_ch[QW].neg ? -work_ch[QW] : work_ch[QW];
      final_w      = ctl_ch[QW].is_div ? quot[WORD_WIDTH-1:0] : side_ch[QW];
      out_valid_in = ctl_ch[QW].valid;
      out_res_in   = PORT_WIDTH'($signed(final_w));
      out_cmp_in   = ctl_ch[QW].cmp;
      out_dz_in    = ctl_ch[QW].dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff <= out_res_in;
      out_cmp_ff <= out_cmp_in;
      out_dz_ff  <= out_dz_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_raw   = out_res_ff;
   assign rsp_compare_true = out_cmp_ff;
   assign rsp_div_by_zero  = out_dz_ff;

endmodule

@@ test/fixed_point_q24_8_alu_unit_test.sv @@
// Self-checking testbench for the Q24.8 fixed-point ALU top level.
// Depends on fxq_alu_pkg and fixed_point_q24_8_alu_unit; predicts each response
// in order and compares it field by field with what the block returns.
module fixed_point_q24_8_alu_unit_test;
   import fxq_alu_pkg::*;

   localparam int LATENCY = WORD_WIDTH_DEF + FRAC_BITS_DEF + 2;
   localparam int RANDOM_OPS = 650;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic signed [31:0]    a;
      logic signed [31:0]    b;
   } alu_op_t;

   typedef struct packed {
      logic signed [31:0] result;
      logic               cmp;
      logic               dz;
   } alu_res_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [FUNC_WIDTH-1:0] req_func = '0;
   logic signed [31:0] req_a_operand = '0;
   logic signed [31:0] req_b_operand = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_result_raw;
   logic rsp_compare_true;
   logic rsp_div_by_zero;

   alu_op_t  pending_ops[$];
   alu_res_t expected_results[$];
   int       error_count = 0;
   int       checked_count = 0;
   bit       stimulus_done = 1'b0;

   fixed_point_q24_8_alu_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_a_operand(req_a_operand),
      .req_b_operand(req_b_operand), .rsp_valid(rsp_valid),
      .rsp_result_raw(rsp_result_raw), .rsp_compare_true(rsp_compare_true),
      .rsp_div_by_zero(rsp_div_by_zero)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic alu_res_t alu_predict(alu_op_t op);
      alu_res_t r;
      logic signed [63:0] a, b, p, q;
      r = '0;
      a = 64'(op.a);
      b = 64'(op.b);
      case (op.func)
         FUNC_ADD: r.result = 32'(a + b);
         FUNC_SUB: r.result = 32'(a - b);
         FUNC_MUL: begin
            p = a * b;
            r.result = 32'(p >>> FRAC_BITS_DEF);
         end
         FUNC_DIV: begin
            if (b == 0) r.dz = 1'b1;
            else begin
               q = (a <<< FRAC_BITS_DEF) / b;
               r.result = 32'(q);
            end
         end
         FUNC_LT: r.cmp = a < b;
         FUNC_GT: r.cmp = a > b;
         FUNC_LE: r.cmp = a <= b;
         FUNC_GE: r.cmp = a >= b;
         FUNC_EQ: r.cmp = a == b;
         FUNC_NE: r.cmp = a != b;
         FUNC_MIN: r.result = 32'((a > b) ? b : a);
         FUNC_MAX: r.result = 32'((a > b) ? a : b);
         FUNC_INC: r.result = 32'(a + 1);
         FUNC_DEC: r.result = 32'(a - 1);
         FUNC_TOINT: begin
            q = a / (64'sd1 <<< FRAC_BITS_DEF);
            r.result = 32'(q);
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %0s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return $urandom_range(0, 4095) - 2048;
         5: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom())};
         default: return $urandom();
      endcase
   endfunction

   // Driver: one transfer per item, random gap before each.
   int gap_left = 0;
   always @(negedge clock) begin
      alu_op_t op;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         // the previous item was transferred at the last rising edge
         gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
         if (pending_ops.size() > 0 && gap_left == 0) begin
            op = pending_ops.pop_front();
            req_func <= op.func;
            req_a_operand <= op.a;
            req_b_operand <= op.b;
            expected_results.push_back(alu_predict(op));
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) gap_left--;
         else if (pending_ops.size() > 0) begin
            op = pending_ops.pop_front();
            req_func <= op.func;
            req_a_operand <= op.a;
            req_b_operand <= op.b;
            start <= 1'b1;
            expected_results.push_back(alu_predict(op));
         end
      end
   end

   // Monitor: responses arrive in request order.
   always @(posedge clock) begin
      alu_res_t want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("MISMATCH unexpected response at %0t", $realtime);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            checked_count++;
            if (rsp_result_raw !== want.result)
               report_mismatch("result_raw", rsp_result_raw, want.result);
            if (rsp_compare_true !== want.cmp)
               report_mismatch("compare_true", 32'(rsp_compare_true), 32'(want.cmp));
            if (rsp_div_by_zero !== want.dz)
               report_mismatch("div_by_zero", 32'(rsp_div_by_zero), 32'(want.dz));
         end
      end
   end

   initial begin
      alu_op_t op;
      int f;
      for (f = 0; f < 16; f++) begin
         pending_ops.push_back('{4'(f), 32'sh8000_0000, 32'sh7fff_ffff});
      end
      pending_ops.push_back('{FUNC_DIV, 32'sh0000_0100, 32'sh0000_0000});
      pending_ops.push_back('{FUNC_DIV, 32'sh8000_0000, 32'shffff_ffff});
      pending_ops.push_back('{FUNC_DIV, 32'sh7fff_ffff, 32'sh0000_0001});
      pending_ops.push_back('{FUNC_MUL, 32'sh8000_0000, 32'sh8000_0000});
      pending_ops.push_back('{FUNC_TOINT, 32'shffff_ff01, 32'sh0});
      pending_ops.push_back('{FUNC_EQ, 32'sh1234_5678, 32'sh1234_5678});
      pending_ops.push_back('{FUNC_INC, 32'sh7fff_ffff, 32'shffff_ffff});
      pending_ops.push_back('{FUNC_DEC, 32'sh8000_0000, 32'shffff_ffff});
      for (int i = 0; i < RANDOM_OPS; i++) begin
         op.func = ($urandom_range(0, 31) == 0) ? 4'hf : 4'($urandom_range(0, 14));
         op.a = pick_operand();
         op.b = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand();
         pending_ops.push_back(op);
      end
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (pending_ops.size() == 0 && expected_results.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d responses over all operations, edge operands and zero divisors.",
               checked_count);
      if (error_count == 0 && expected_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
